// ----- src/first_fit_block_allocator_unit_defines.svh -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit_defines
// Assertion macros used by the allocator controller RTL.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define FFBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define FFBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants for the first-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
    localparam int SZ_W         = 21;
    localparam int REQ_W        = 20;
    localparam int ST_W         = 3;
    localparam int NEED_W       = SZ_W + 2;
    localparam int HEADER_BYTES = 24;
    localparam int WORD_BYTES   = 8;

    localparam logic [ST_W-1:0] ST_REUSED   = 3'd0;
    localparam logic [ST_W-1:0] ST_NEW      = 3'd1;
    localparam logic [ST_W-1:0] ST_ZERO     = 3'd2;
    localparam logic [ST_W-1:0] ST_NOSPACE  = 3'd3;
    localparam logic [ST_W-1:0] ST_LARGE    = 3'd4;
    localparam logic [ST_W-1:0] ST_FREED    = 3'd5;
    localparam logic [ST_W-1:0] ST_BADINDEX = 3'd6;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic CFG_HEAP_BYTES  = 1'b0;
    localparam logic CFG_LARGE_THRESH = 1'b1;

    // token travelling down the cell chain
    typedef struct packed {
        logic             active;
        logic             op_free;
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [SZ_W-1:0]  size;
        logic [SZ_W-1:0]  offset;
    } t_tok;

    // table write for a newly carved block
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [SZ_W-1:0]  size;
        logic [SZ_W-1:0]  offset;
    } t_wr;

    typedef struct packed {
        logic [SZ_W-1:0]  granted_size;
        logic [SZ_W-1:0]  data_offset;
        logic [IDX_W-1:0] block_index;
        logic [ST_W-1:0]  status;
    } t_res;

endpackage

`default_nettype wire

// ----- src/first_fit_block_allocator_unit.sv -----
// Table scan requests (reuse, new block, no space, free) launch a token through
//   the cell chain; zero size, large and bad index go straight to the result.
// One request at a time: the scan token walks the 64-cell chain one cell per
//   cycle, and a new request is taken only once the result has been handed on.
// Reset (i_rst_n low, synchronous): block count and bump pointer cleared,
//   registers back to heap_bytes 1048576 and large_threshold 131072.
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// First-fit heap block allocator built as a chain of table cells.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire [20:0]  i_cfg_data,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire [31:0]  i_s_tdata,   // [19:0] request_size, [25:20] free_index, rest zero
    input  wire         i_s_tuser,   // [0] action
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [55:0] o_m_tdata    // [2:0] status, [8:3] block_index,
                                     // [29:9] data_offset, [50:30] granted_size
);

    ffba_pkg::t_tok                w_tok [0:ffba_pkg::MAX_BLOCKS];
    ffba_pkg::t_wr                 w_wr;
    ffba_pkg::t_res                w_res;
    logic [ffba_pkg::CNT_W-1:0]    w_count;

    ffba_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_act        (i_s_tuser),
        .i_req_size   (i_s_tdata[19:0]),
        .i_free_index (i_s_tdata[25:20]),
        .i_in_valid   (i_s_tvalid),
        .o_in_ready   (o_s_tready),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_res        (w_res),
        .o_launch     (w_tok[0]),
        .i_chain_out  (w_tok[ffba_pkg::MAX_BLOCKS]),
        .o_wr         (w_wr),
        .o_count      (w_count)
    );

    for (genvar k = 0; k < ffba_pkg::MAX_BLOCKS; k++) begin : g_cell
        ffba_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (ffba_pkg::IDX_W'(k)),
            .i_count (w_count),
            .i_wr    (w_wr),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k+1])
        );
    end

    assign o_m_tdata = {5'd0, w_res};

endmodule

`default_nettype wire

// ----- src/ffba_cell.sv -----
// ----------------------------------------------------------------------------
// ffba_cell
// One table entry. Checks the passing token against its entry and hands the
// token on to the next cell in the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_cell (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire [ffba_pkg::IDX_W-1:0]  i_idx,
    input  wire [ffba_pkg::CNT_W-1:0]  i_count,
    input  ffba_pkg::t_wr              i_wr,
    input  ffba_pkg::t_tok             i_tok,
    output ffba_pkg::t_tok             o_tok
);

    logic [ffba_pkg::SZ_W-1:0] r_size;
    logic [ffba_pkg::SZ_W-1:0] r_offset;
    logic                      r_free;
    ffba_pkg::t_tok            r_tok;
    ffba_pkg::t_tok            n_tok;

    logic w_live;
    logic w_hit_alloc;
    logic w_hit_free;

    assign w_live      = ({1'b0, i_idx} < i_count);
    assign w_hit_alloc = i_tok.active && !i_tok.op_free && !i_tok.found && w_live
                         && r_free && (r_size >= i_tok.size);
    assign w_hit_free  = i_tok.active && i_tok.op_free && (i_tok.idx == i_idx);

    always_comb begin
        n_tok = i_tok;
        if (w_hit_alloc || w_hit_free) begin
            n_tok.found  = 1'b1;
            n_tok.idx    = i_idx;
            n_tok.size   = r_size;
            n_tok.offset = r_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.active <= 1'b0;
        end else begin
            r_tok.active <= n_tok.active;
        end
        r_tok.op_free <= n_tok.op_free;
        r_tok.found   <= n_tok.found;
        r_tok.idx     <= n_tok.idx;
        r_tok.size    <= n_tok.size;
        r_tok.offset  <= n_tok.offset;
    end

    // entry storage: no reset, only entries below the block count are looked at
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx == i_idx)) begin
            r_size   <= i_wr.size;
            r_offset <= i_wr.offset;
            r_free   <= 1'b0;
        end else if (w_hit_alloc) begin
            r_free <= 1'b0;
        end else if (w_hit_free) begin
            r_free <= 1'b1;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// ----- src/ffba_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffba_ctrl
// Request decode, bump pointer, block count, configuration and result
// register. Launches a token into the cell chain for a scan and finishes the
// request when the token leaves the last cell; others are answered without a scan.
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_fit_block_allocator_unit_defines.svh"

module ffba_ctrl (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire                         i_cfg_index,
    input  wire [ffba_pkg::SZ_W-1:0]    i_cfg_data,
    input  wire                         i_act,
    input  wire [ffba_pkg::REQ_W-1:0]   i_req_size,
    input  wire [ffba_pkg::IDX_W-1:0]   i_free_index,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output ffba_pkg::t_res              o_res,
    output ffba_pkg::t_tok              o_launch,
    input  ffba_pkg::t_tok              i_chain_out,
    output ffba_pkg::t_wr               o_wr,
    output logic [ffba_pkg::CNT_W-1:0]  o_count
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_PEND = 2'd2;

    localparam logic [ffba_pkg::SZ_W-1:0] WMASK = ffba_pkg::SZ_W'(ffba_pkg::WORD_BYTES - 1);
    localparam logic [ffba_pkg::SZ_W-1:0] HDR   = ffba_pkg::SZ_W'(ffba_pkg::HEADER_BYTES);

    logic [1:0]                   r_state;
    logic [ffba_pkg::SZ_W-1:0]    r_heap_bytes;
    logic [ffba_pkg::SZ_W-1:0]    r_large_thr;
    logic [ffba_pkg::CNT_W-1:0]   r_count;
    logic [ffba_pkg::SZ_W-1:0]    r_heap_top;
    logic [ffba_pkg::SZ_W-1:0]    r_rounded;
    ffba_pkg::t_tok               r_launch;
    ffba_pkg::t_wr                r_wr;
    ffba_pkg::t_res               r_res;
    ffba_pkg::t_res               r_out;
    logic                         r_out_valid;

    logic                         w_accept;
    logic [ffba_pkg::SZ_W-1:0]    w_rounded;
    logic [ffba_pkg::NEED_W-1:0]  w_need;
    logic                         w_nospace;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;

    assign w_rounded = ({1'b0, i_req_size} + WMASK) & ~WMASK;
    assign w_need    = ffba_pkg::NEED_W'(r_heap_top) + ffba_pkg::NEED_W'(HDR)
                       + ffba_pkg::NEED_W'(r_rounded);
    assign w_nospace = (r_count >= ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS))
                       || (w_need > ffba_pkg::NEED_W'(r_heap_bytes));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_bytes <= ffba_pkg::SZ_W'(1048576);
            r_large_thr  <= ffba_pkg::SZ_W'(131072);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ffba_pkg::CFG_HEAP_BYTES:   r_heap_bytes <= i_cfg_data;
                ffba_pkg::CFG_LARGE_THRESH: r_large_thr  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_count         <= '0;
            r_heap_top      <= '0;
            r_launch.active <= 1'b0;
            r_wr.en         <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_launch.active <= 1'b0;
            r_wr.en         <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_rounded <= w_rounded;
                        r_res     <= '0;
                        if (i_act == ffba_pkg::ACT_FREE) begin
                            if ({1'b0, i_free_index} >= r_count) begin
                                r_res.status      <= ffba_pkg::ST_BADINDEX;
                                r_res.block_index <= i_free_index;
                                r_state           <= S_PEND;
                            end else begin
                                r_launch.active <= 1'b1;
                                r_state         <= S_SCAN;
                            end
                        end else if (i_req_size == '0) begin
                            r_res.status <= ffba_pkg::ST_ZERO;
                            r_state      <= S_PEND;
                        end else if (w_rounded >= r_large_thr) begin
                            r_res.status       <= ffba_pkg::ST_LARGE;
                            r_res.granted_size <= w_rounded;
                            r_state            <= S_PEND;
                        end else begin
                            r_launch.active <= 1'b1;
                            r_state         <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (i_chain_out.active) begin
                        r_state <= S_PEND;
                        if (i_chain_out.op_free) begin
                            r_res.status       <= ffba_pkg::ST_FREED;
                            r_res.block_index  <= i_chain_out.idx;
                            r_res.data_offset  <= i_chain_out.offset + HDR;
                            r_res.granted_size <= i_chain_out.size;
                        end else if (i_chain_out.found) begin
                            r_res.status       <= ffba_pkg::ST_REUSED;
                            r_res.block_index  <= i_chain_out.idx;
                            r_res.data_offset  <= i_chain_out.offset + HDR;
                            r_res.granted_size <= i_chain_out.size;
                        end else if (w_nospace) begin
                            r_res.status       <= ffba_pkg::ST_NOSPACE;
                            r_res.granted_size <= r_rounded;
                        end else begin
                            r_res.status       <= ffba_pkg::ST_NEW;
                            r_res.block_index  <= r_count[ffba_pkg::IDX_W-1:0];
                            r_res.data_offset  <= r_heap_top + HDR;
                            r_res.granted_size <= r_rounded;
                            r_wr.en            <= 1'b1;
                            r_count            <= r_count + ffba_pkg::CNT_W'(1);
                            r_heap_top         <= w_need[ffba_pkg::SZ_W-1:0];
                        end
                    end
                end
                S_PEND: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload of the launch token, the table write and the output result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_launch.op_free <= i_act;
            r_launch.found   <= 1'b0;
            r_launch.idx     <= i_free_index;
            r_launch.size    <= w_rounded;
            r_launch.offset  <= '0;
        end
        r_wr.idx    <= r_count[ffba_pkg::IDX_W-1:0];
        r_wr.size   <= r_rounded;
        r_wr.offset <= r_heap_top;
        if ((r_state == S_PEND) && (!r_out_valid || i_out_ready)) begin
            r_out <= r_res;
        end
    end

    assign o_launch    = r_launch;
    assign o_wr        = r_wr;
    assign o_count     = r_count;
    assign o_res       = r_out;
    assign o_out_valid = r_out_valid;

    `FFBA_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS), "block count past table size")
    `FFBA_ASSERT_NOW(a_token_in_scan, i_clk, i_rst_n, i_chain_out.active,
        r_state == S_SCAN, "token left chain outside a scan")
    `FFBA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept,
        r_state != S_IDLE, "accepted transaction left controller idle")
    `FFBA_ASSERT_NEXT(a_write_new, i_clk, i_rst_n, r_wr.en,
        r_out_valid || r_state == S_PEND, "table write without a pending result")

endmodule

`default_nettype wire
